/* design/rcfp_pkg.sv */
package rcfp_pkg;

	// Item kinds on the input channel
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_RC   = 2'd0;
	localparam logic [1:0] KIND_LINK = 2'd1;
	localparam logic [1:0] KIND_NAME = 2'd2;

	// Frame types that produce results
	localparam logic [7:0] TYPE_LINK = 8'h14;
	localparam logic [7:0] TYPE_RC   = 8'h16;
	localparam logic [7:0] TYPE_INFO = 8'h29;

	// Configuration register indexes
	localparam logic [1:0] REG_SYNC = 2'd0;
	localparam logic [1:0] REG_GAP  = 2'd1;
	localparam logic [1:0] REG_POLY = 2'd2;

	// Configuration reset values
	localparam logic [7:0] SYNC_RST = 8'hC8;
	localparam logic [7:0] GAP_RST  = 8'd5;
	localparam logic [7:0] POLY_RST = 8'hD5;

	// Quiet counter saturation
	localparam logic [7:0] QUIET_MAX = 8'hFF;

	// Payload layout
	localparam int CH_BITS     = 11;
	localparam int ACC_W       = CH_BITS + 7;
	localparam int CNT_W       = 5;
	localparam logic [3:0] RC_LAST   = 4'd15;
	localparam logic [3:0] LINK_LAST = 4'd9;
	localparam int RC_BASE     = 3;
	localparam int LINK_BASE   = 3;
	localparam int NAME_BASE   = 5;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  index;
		logic [10:0] value;
		logic        last;
	} out_item_t;

	// Good frame finished: start of result emission
	typedef struct packed {
		logic       start;
		logic [7:0] ftype;
	} frame_done_t;

	// One byte through the CRC8, MSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

endpackage

/* design/rcfp_store.sv */
module rcfp_store import rcfp_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       data_s1;
	logic             vld_s1;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Entry written since reset; unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_s1 <= mem[rd_addr];
			vld_s1  <= vld_q[rd_addr];
		end
	end

	assign rd_data = vld_s1 ? data_s1 : 8'd0;

endmodule

/* design/rcfp_rx.sv */
module rcfp_rx import rcfp_pkg::*; #(
	parameter int MAX_FRAME = 64,
	parameter int AW        = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  in_item_t      in_item,
	input  logic [7:0]    sync_address,
	input  logic [7:0]    gap_limit_ms,
	input  logic [7:0]    crc_poly,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	output frame_done_t   done
);

	localparam logic [1:0] PH_SYNC = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	localparam logic [7:0]  LEN_MIN = 8'd2;
	localparam logic [7:0]  LEN_MAX = 8'(MAX_FRAME - 2);
	localparam logic [AW-1:0] ADDR_SYNC = AW'(0);
	localparam logic [AW-1:0] ADDR_LEN  = AW'(1);
	localparam logic [AW-1:0] ADDR_TYPE = AW'(2);

	logic [1:0]    phase_q;
	logic [AW-1:0] len_q;
	logic [AW-1:0] pos_q;
	logic [7:0]    crc_q;
	logic [7:0]    quiet_q;
	logic [7:0]    type_q;

	logic          is_byte;
	logic          is_tick;
	logic [7:0]    b;
	logic [1:0]    phase_eff;
	logic [AW:0]   pos_nx;
	logic          frame_end;
	logic          len_ok;
	logic          type_known;

	assign b       = in_item.data_byte;
	assign is_byte = in_fire && (in_item.op == OP_BYTE);
	assign is_tick = in_fire && (in_item.op == OP_TICK);

	// Resync on a line gap before handling the byte
	assign phase_eff  = (quiet_q > gap_limit_ms) ? PH_SYNC : phase_q;
	assign pos_nx     = {1'b0, pos_q} + (AW+1)'(1);
	assign frame_end  = pos_nx >= ({1'b0, len_q} + (AW+1)'(2));
	assign len_ok     = (b >= LEN_MIN) && (b <= LEN_MAX);
	assign type_known = (type_q == TYPE_RC) || (type_q == TYPE_LINK) || (type_q == TYPE_INFO);

	// Store writes
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = b;
		unique case (phase_eff)
			PH_SYNC: begin
				wr_en   = is_byte && (b == sync_address);
				wr_addr = ADDR_SYNC;
			end
			PH_LEN: begin
				wr_en   = is_byte && len_ok;
				wr_addr = ADDR_LEN;
			end
			PH_BODY: begin
				wr_en   = is_byte;
				wr_addr = pos_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Hand a good frame to the emitter
	assign done.start = is_byte && (phase_eff == PH_BODY) && frame_end && (crc_q == b) &&
		type_known;
	assign done.ftype = type_q;

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			len_q   <= '0;
			pos_q   <= '0;
			crc_q   <= '0;
			quiet_q <= QUIET_MAX;
			type_q  <= '0;
		end else if (is_tick) begin
			if (quiet_q != QUIET_MAX) begin
				quiet_q <= quiet_q + 8'd1;
			end
		end else if (is_byte) begin
			quiet_q <= '0;
			unique case (phase_eff)
				PH_SYNC: begin
					phase_q <= (b == sync_address) ? PH_LEN : PH_SYNC;
				end
				PH_LEN: begin
					if (len_ok) begin
						len_q   <= b[AW-1:0];
						pos_q   <= ADDR_TYPE;
						crc_q   <= '0;
						phase_q <= PH_BODY;
					end else begin
						phase_q <= PH_SYNC;
					end
				end
				PH_BODY: begin
					pos_q <= pos_nx[AW-1:0];
					if (pos_q == ADDR_TYPE) begin
						type_q <= b;
					end
					if (frame_end) begin
						phase_q <= PH_SYNC;
					end else begin
						crc_q <= crc8_step(crc_q, b, crc_poly);
					end
				end
				default: begin
					phase_q <= PH_SYNC;
				end
			endcase
		end
	end

endmodule

/* design/rcfp_emit.sv */
module rcfp_emit import rcfp_pkg::*; #(
	parameter int NAME_LEN = 16,
	parameter int AW       = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  frame_done_t   done,
	output logic          busy,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  logic [7:0]    rd_data,
	output logic          out_valid,
	input  logic          out_ready,
	output out_item_t     out_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_NEXT = 2'd1;
	localparam logic [1:0] S_DATA = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	localparam logic [3:0]       NAME_LAST = 4'(NAME_LEN - 1);
	localparam logic [CNT_W-1:0] CH_CNT    = CNT_W'(CH_BITS);
	localparam logic [CNT_W-1:0] BYTE_CNT  = CNT_W'(8);

	logic [1:0]       st_q;
	logic [1:0]       kind_q;
	logic [3:0]       idx_q;
	logic [AW-1:0]    addr_q;
	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       byte_q;
	out_item_t        out_q;
	logic             out_valid_q;

	logic             out_free;
	logic             need_read;
	out_item_t        res;

	assign out_free  = !out_valid_q || out_ready;
	assign need_read = !((kind_q == KIND_RC) && (cnt_q >= CH_CNT)) &&
		!((kind_q == KIND_NAME) && (idx_q == NAME_LAST));
	assign rd_en     = (st_q == S_NEXT) && need_read;
	assign rd_addr   = addr_q;
	assign busy      = st_q != S_IDLE;

	// Result of the current step
	always_comb begin
		res.kind  = kind_q;
		res.index = idx_q;
		res.value = {3'd0, byte_q};
		res.last  = 1'b0;
		unique case (kind_q)
			KIND_RC: begin
				res.value = acc_q[CH_BITS-1:0];
				res.last  = idx_q == RC_LAST;
			end
			KIND_LINK: begin
				res.last = idx_q == LINK_LAST;
			end
			KIND_NAME: begin
				res.last = byte_q == 8'd0;
			end
			default: begin
				res.last = 1'b1;
			end
		endcase
	end

	// Sequencer: read bytes, gather bits, emit one result at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			kind_q <= KIND_RC;
			idx_q  <= '0;
			addr_q <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			byte_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (done.start) begin
						idx_q <= '0;
						acc_q <= '0;
						cnt_q <= '0;
						st_q  <= S_NEXT;
						priority if (done.ftype == TYPE_RC) begin
							kind_q <= KIND_RC;
							addr_q <= AW'(RC_BASE);
						end else if (done.ftype == TYPE_LINK) begin
							kind_q <= KIND_LINK;
							addr_q <= AW'(LINK_BASE);
						end else begin
							kind_q <= KIND_NAME;
							addr_q <= AW'(NAME_BASE);
						end
					end
				end
				S_NEXT: begin
					if (need_read) begin
						addr_q <= addr_q + AW'(1);
						st_q   <= S_DATA;
					end else begin
						if (kind_q == KIND_NAME) begin
							byte_q <= '0;
						end
						st_q <= S_EMIT;
					end
				end
				S_DATA: begin
					if (kind_q == KIND_RC) begin
						acc_q <= acc_q | (ACC_W'(rd_data) << cnt_q);
						cnt_q <= cnt_q + BYTE_CNT;
						st_q  <= S_NEXT;
					end else begin
						byte_q <= rd_data;
						st_q   <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						idx_q <= idx_q + 4'd1;
						st_q  <= res.last ? S_IDLE : S_NEXT;
						if (kind_q == KIND_RC) begin
							acc_q <= acc_q >> CH_BITS;
							cnt_q <= cnt_q - CH_CNT;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((st_q == S_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == S_EMIT) && out_free) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* design/rc_frame_parser_crc8_unit.sv */
// Radio-control frame parser with CRC8 check.
// Input channel (in_valid/in_ready/in_data) carries one transaction per
// received byte or per one-millisecond tick. Bytes and ticks are taken one per
// cycle while no frame is being unpacked.
// Output channel (out_valid/out_ready/out_data) delivers decoded results: 16
// RC channels, 10 link statistics, or device name characters ending in a zero.
// When the last byte of a good frame is taken, a sequencer unpacks it from the
// frame store, which has a single registered read port: each byte is requested
// and then taken in, and a result is registered for output once it is gathered.
// The input stays stalled while the frame is being unpacked.
// A stalled receiver holds the sequencer at its current result; a finished
// result waits in the output register, and input resumes once the last
// result of the frame is registered.
// Reset puts the parser into sync hunting, loads the configuration defaults and
// marks every store entry unwritten, so it reads as zero; no clearing pass.
// Configuration writes (cfg_we/cfg_idx/cfg_wdata) take effect at once; the user
// must make them only while the block is idle; the block does not enforce it.
module rc_frame_parser_crc8_unit import rcfp_pkg::*; #(
	parameter int MAX_FRAME = 64,
	parameter int NAME_LEN  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_wdata
);

	localparam int AW = $clog2(MAX_FRAME);

	logic [7:0]    sync_q;
	logic [7:0]    gap_q;
	logic [7:0]    poly_q;

	logic          in_fire;
	logic          busy;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	frame_done_t   done;

	assign in_ready = !busy;
	assign in_fire  = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RST;
			gap_q  <= GAP_RST;
			poly_q <= POLY_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SYNC: sync_q <= cfg_wdata;
				REG_GAP:  gap_q  <= cfg_wdata;
				REG_POLY: poly_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	rcfp_rx #(
		.MAX_FRAME(MAX_FRAME),
		.AW       (AW)
	) u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.in_item     (in_data),
		.sync_address(sync_q),
		.gap_limit_ms(gap_q),
		.crc_poly    (poly_q),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.done        (done)
	);

	rcfp_store #(
		.DEPTH(MAX_FRAME),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	rcfp_emit #(
		.NAME_LEN(NAME_LEN),
		.AW      (AW)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.done     (done),
		.busy     (busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// A finished frame only arrives while the sequencer is free
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done.start |-> !busy)
		else $error("frame handed over while emitter busy");

	// The sequencer picks up every finished frame
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done.start |=> busy)
		else $error("finished frame not picked up");

	// Store reads and writes never overlap
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !wr_en)
		else $error("store read during write");

	// Link statistics end at the tenth byte
	a_link_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.last && (out_data.kind == KIND_LINK)) |->
		(out_data.index == LINK_LAST))
		else $error("link statistics ended early");

endmodule

/* dv/tb_rc_frame_parser_crc8_unit.sv */
`timescale 1ns / 1ps

module tb_rc_frame_parser_crc8_unit;
	import rcfp_pkg::*;

	localparam int MAX_FRAME     = 64;
	localparam int NAME_LEN      = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 100;
	localparam int LEAD_TICKS    = 8;
	localparam int PHASE_BYTES   = 28;
	localparam logic [7:0] TYPE_PING = 8'h28;

	typedef enum logic [1:0] {PH_HUNT, PH_LENGTH, PH_BODY} parse_phase_e;
	typedef enum int {RX_FLOW, RX_HOLD, RX_CHOPPY} rx_mode_e;

	// Shadow parser: tracks the frame state and queues the decoded results it predicts
	class frame_decode_sb;
		logic [7:0]   sync_addr;
		logic [7:0]   gap_limit;
		logic [7:0]   poly;
		parse_phase_e phase;
		logic [7:0]   frame_mem [MAX_FRAME];
		logic [5:0]   len_field;
		logic [6:0]   wr_pos;
		logic [7:0]   body_crc;
		logic [7:0]   quiet_ms;
		out_item_t    pending_results[$];
		int unsigned  mismatches;

		function new();
			sync_addr = SYNC_RST;
			gap_limit = GAP_RST;
			poly = POLY_RST;
			phase = PH_HUNT;
			foreach (frame_mem[i]) frame_mem[i] = 8'h00;
			len_field = '0;
			wr_pos = '0;
			body_crc = '0;
			quiet_ms = QUIET_MAX;
			mismatches = 0;
		endfunction

		function void set_config(input logic [7:0] s, g, p);
			sync_addr = s;
			gap_limit = g;
			poly = p;
		endfunction

		// Shift one byte through the CRC8, MSB first
		function logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
			logic [7:0] c;
			c = crc ^ b;
			for (int k = 0; k < 8; k++)
				c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
			return c;
		endfunction

		// Positions past the store read as zero
		function logic [7:0] mem_at(input int pos);
			return (pos < MAX_FRAME) ? frame_mem[pos] : 8'h00;
		endfunction

		function void push_result(input logic [1:0] kind, input int idx,
			input logic [10:0] value, input bit last);
			out_item_t r;
			r.kind = kind;
			r.index = idx[3:0];
			r.value = value;
			r.last = last;
			pending_results.push_back(r);
		endfunction

		// Decode a good frame by its type; reads are not bounded by the frame length
		function void unpack_frame();
			logic [7:0]  ftype;
			logic [23:0] w;
			int          bitpos;
			int          base;
			int          n;
			ftype = mem_at(2);
			if (ftype == TYPE_RC) begin
				for (int ch = 0; ch < 16; ch++) begin
					bitpos = 11 * ch;
					base = RC_BASE + bitpos / 8;
					w = {mem_at(base + 2), mem_at(base + 1), mem_at(base)};
					w = w >> (bitpos % 8);
					push_result(KIND_RC, ch, w[10:0], ch == 15);
				end
			end else if (ftype == TYPE_LINK) begin
				for (int s = 0; s < 10; s++)
					push_result(KIND_LINK, s, {3'b000, mem_at(LINK_BASE + s)}, s == 9);
			end else if (ftype == TYPE_INFO) begin
				n = 0;
				while (n < NAME_LEN - 1 && mem_at(NAME_BASE + n) != 8'h00) begin
					push_result(KIND_NAME, n, {3'b000, mem_at(NAME_BASE + n)}, 1'b0);
					n++;
				end
				push_result(KIND_NAME, n, 11'd0, 1'b1);
			end
		endfunction

		// Advance the shadow parser by one accepted input transaction
		function void note_input(input in_item_t it);
			logic [7:0] b;
			int         pos;
			b = it.data_byte;
			if (it.op == OP_TICK) begin
				if (quiet_ms != QUIET_MAX)
					quiet_ms++;
				return;
			end
			if (quiet_ms > gap_limit)
				phase = PH_HUNT;
			quiet_ms = '0;
			case (phase)
				PH_HUNT: begin
					if (b == sync_addr) begin
						frame_mem[0] = b;
						phase = PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					if (b < 2 || b > MAX_FRAME - 2) begin
						phase = PH_HUNT;
					end else begin
						len_field = b[5:0];
						frame_mem[1] = b;
						wr_pos = 7'd2;
						body_crc = 8'h00;
						phase = PH_BODY;
					end
				end
				default: begin
					pos = wr_pos;
					if (pos < MAX_FRAME)
						frame_mem[pos] = b;
					pos++;
					wr_pos = pos[6:0];
					if (pos >= len_field + 2) begin
						if (body_crc == b)
							unpack_frame();
						phase = PH_HUNT;
					end else begin
						body_crc = crc_next(body_crc, b);
					end
				end
			endcase
		endfunction

		// Compare one output transaction against the oldest prediction
		function void check_result(input out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d index %0d value %0d last %0d",
					got.kind, got.index, got.value, got.last);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				mismatches++;
			end
			if (got.index !== want.index) begin
				$error("index: expected %0d, actual %0d", want.index, got.index);
				mismatches++;
			end
			if (got.value !== want.value) begin
				$error("value: expected %0d, actual %0d", want.value, got.value);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [7:0] cfg_wdata;

	frame_decode_sb sb;
	in_item_t       stim_q[$];
	int             byte_count;
	int             mid_tick_pct;
	int             burst_left;
	int             cycle_count;
	bit             long_done;

	rc_frame_parser_crc8_unit #(
		.MAX_FRAME(MAX_FRAME),
		.NAME_LEN (NAME_LEN)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_rc_frame_parser_crc8_unit: FAIL");
		$finish;
	end

	// Stall the receiver: free-flowing, held, or choppy stretches
	initial begin : receiver
		int       run_left;
		rx_mode_e mode;
		out_ready = 1'b0;
		run_left = 0;
		mode = RX_FLOW;
		forever begin
			@(negedge clk);
			if (run_left == 0) begin
				mode = rx_mode_e'($urandom_range(0, 2));
				run_left = (mode == RX_HOLD) ? $urandom_range(1, 20) : $urandom_range(1, 40);
			end
			run_left--;
			case (mode)
				RX_FLOW: out_ready <= 1'b1;
				RX_HOLD: out_ready <= 1'b0;
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Observe completed transactions on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	function automatic void add_byte(input logic [7:0] b);
		in_item_t it;
		it.op = OP_BYTE;
		it.data_byte = b;
		stim_q.push_back(it);
		byte_count++;
	endfunction

	function automatic void add_ticks(input int n);
		in_item_t it;
		for (int i = 0; i < n; i++) begin
			it.op = OP_TICK;
			it.data_byte = 8'($urandom_range(0, 255));
			stim_q.push_back(it);
		end
	endfunction

	// Queue a whole frame under the current sync address and polynomial
	function automatic void add_frame(input logic [7:0] ftype, input int len,
		input logic [7:0] body[$], input bit good_crc);
		logic [7:0] crc;
		add_byte(sb.sync_addr);
		add_byte(len[7:0]);
		add_byte(ftype);
		crc = sb.crc_next(8'h00, ftype);
		foreach (body[i]) begin
			add_byte(body[i]);
			crc = sb.crc_next(crc, body[i]);
			if ($urandom_range(0, 99) < mid_tick_pct)
				add_ticks($urandom_range(1, 2));
		end
		add_byte(good_crc ? crc : crc ^ 8'($urandom_range(1, 255)));
	endfunction

	// Build a random phase: mostly well-formed frames, plus noise, broken frames and ticks
	task automatic gen_random(input int budget);
		int         start;
		int         r;
		int         n;
		int         len;
		logic [7:0] ftype;
		logic [7:0] body[$];
		start = byte_count;
		add_ticks(LEAD_TICKS);
		while (byte_count - start < budget) begin
			// quiet time before the next event, now and then past the gap limit
			n = $urandom_range(0, 2);
			if (n > sb.gap_limit)
				n = sb.gap_limit;
			if ($urandom_range(0, 9) == 0 && sb.gap_limit < 64)
				n = sb.gap_limit + 1;
			add_ticks(n);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				case ($urandom_range(0, 9))
					0, 1, 2: ftype = TYPE_RC;
					3, 4:    ftype = TYPE_LINK;
					5, 6:    ftype = TYPE_INFO;
					7:       ftype = TYPE_PING;
					default: ftype = 8'($urandom_range(0, 255));
				endcase
				if (!long_done) begin
					len = MAX_FRAME - 2;
					long_done = 1'b1;
				end else if (ftype == TYPE_RC && $urandom_range(0, 1) == 1) begin
					len = 24;
				end else if ($urandom_range(0, 6) == 0) begin
					len = $urandom_range(13, 30);
				end else begin
					len = $urandom_range(2, 12);
				end
				body.delete();
				for (int i = 0; i < len - 2; i++) begin
					if (ftype == TYPE_INFO && i >= 2 && $urandom_range(0, 9) != 0)
						body.push_back(8'($urandom_range(1, 255)));
					else
						body.push_back(8'($urandom_range(0, 255)));
				end
				add_frame(ftype, len, body, $urandom_range(0, 6) != 0);
			end else if (r < 82) begin
				// line noise, sometimes carrying the sync address
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					add_byte(($urandom_range(0, 3) == 0) ? sb.sync_addr : 8'($urandom_range(0, 255)));
			end else if (r < 94) begin
				add_byte(sb.sync_addr);
				if ($urandom_range(0, 1) == 1) begin
					// length out of range on either side
					add_byte(($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 1))
						: 8'($urandom_range(MAX_FRAME - 1, 255)));
				end else begin
					// truncated frame, then silence
					add_byte(8'($urandom_range(2, 20)));
					n = $urandom_range(0, 3);
					for (int i = 0; i < n; i++)
						add_byte(8'($urandom_range(0, 255)));
					if (sb.gap_limit < 64)
						add_ticks(sb.gap_limit + 1);
				end
			end else begin
				add_ticks($urandom_range(1, 10));
			end
		end
	endtask

	// Drive queued transactions in bursts with random gaps
	task automatic send_all();
		in_item_t it;
		int       gap;
		while (stim_q.size() != 0) begin
			it = stim_q.pop_front();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			in_valid <= 1'b1;
			in_data <= it;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			burst_left--;
			@(negedge clk);
		end
		in_valid <= 1'b0;
	endtask

	// Hold until every predicted result has arrived and the unpacker has settled
	task automatic wait_idle();
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_config(input logic [7:0] s, g, p);
		cfg_we <= 1'b1;
		cfg_idx <= REG_SYNC;
		cfg_wdata <= s;
		@(negedge clk);
		cfg_idx <= REG_GAP;
		cfg_wdata <= g;
		@(negedge clk);
		cfg_idx <= REG_POLY;
		cfg_wdata <= p;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_config(s, g, p);
	endtask

	initial begin : stimulus
		logic [7:0] payload[$];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_SYNC;
		cfg_wdata = 8'h00;
		byte_count = 0;
		mid_tick_pct = 0;
		burst_left = 0;
		long_done = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: tick, RC frame reading cleared store, bad lengths, link, gap, name
		add_ticks(1);
		payload.delete();
		add_frame(TYPE_RC, 2, payload, 1'b1);
		add_byte(SYNC_RST);
		add_byte(SYNC_RST);
		add_byte(SYNC_RST);
		add_byte(8'd1);
		payload.push_back(8'hAA);
		payload.push_back(8'h55);
		add_frame(TYPE_LINK, 4, payload, 1'b1);
		add_byte(SYNC_RST);
		add_byte(8'd2);
		add_ticks(GAP_RST + 1);
		payload.delete();
		add_frame(TYPE_INFO, 2, payload, 1'b1);
		send_all();

		// Random phases over several settings: defaults, then extremes, then a random one
		mid_tick_pct = 8;
		gen_random(PHASE_BYTES);
		send_all();
		wait_idle();
		apply_config(8'h00, 8'h00, 8'hFF);
		gen_random(PHASE_BYTES);
		send_all();
		wait_idle();
		apply_config(8'hFF, 8'hFF, 8'h00);
		gen_random(PHASE_BYTES);
		send_all();
		wait_idle();
		apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(1, 12)),
			8'($urandom_range(0, 255)));
		gen_random(PHASE_BYTES);
		send_all();
		wait_idle();

		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("tb_rc_frame_parser_crc8_unit: PASS");
		else
			$display("tb_rc_frame_parser_crc8_unit: FAIL");
		$finish;
	end

endmodule
